// ===== design/ecefgeo_pkg.sv =====
package ecefgeo_pkg;

    localparam int DATA_W            = 64;
    localparam int RADIUS_BITS       = 34;
    localparam int OUT_BITS          = 32;
    localparam int QBITS             = 62;
    localparam int TAB_LEN           = 48;
    localparam int CFG_ADDR_W        = 4;
    localparam int DEF_COORD_BITS    = 36;
    localparam int DEF_ANGLE_BITS    = 32;
    localparam int DEF_CORDIC_STAGES = 32;

    localparam logic [CFG_ADDR_W-1:0] ADDR_EQ_RADIUS    = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_POLAR_RADIUS = 4'd8;

    localparam logic [63:0] Q62_ONE    = 64'h4000_0000_0000_0000;
    localparam logic [63:0] HALF_PI    = 64'h1000_0000_0000_0000;
    localparam logic [63:0] QUARTER_PI = 64'h0800_0000_0000_0000;
    localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A95;

    localparam logic [RADIUS_BITS-1:0] RESET_A = 34'd6378137000;
    localparam logic [RADIUS_BITS-1:0] RESET_B = 34'd6356752314;

    // Ellipsoid terms derived from the radius registers.
    typedef struct packed {
        logic        busy;
        logic        b_le_a;
        logic [63:0] u;
        logic [63:0] w;
    } t_cfg;

    // Plain restoring division, used for elaboration-time constants only.
    function automatic logic [63:0] f_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        int k;
        rem = '0;
        q   = '0;
        for (k = 63; k >= 0; k--) begin
            rem = {rem[63:0], n[k]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // (hi:lo) / d with hi < d.
    function automatic logic [63:0] f_div_wide(input logic [63:0] hi, input logic [63:0] lo,
                                               input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        int k;
        rem = {1'b0, hi};
        q   = lo;
        for (k = 0; k < 64; k++) begin
            rem = {rem[63:0], q[63]};
            q   = {q[62:0], 1'b0};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) with pi = 2^61, from the arctangent series in Q62.
    function automatic logic signed [63:0] f_step_angle(input int i);
        logic [63:0]  rad;
        logic [63:0]  term;
        logic [127:0] prod;
        logic [63:0]  res;
        int k;
        int e;
        rad = '0;
        for (k = 0; k < 64; k++) begin
            e = 62 - i * (2 * k + 1);
            if (e >= 0) begin
                term = f_udiv(64'd1 << e, 64'(2 * k + 1));
                rad  = k[0] ? rad - term : rad + term;
            end
        end
        prod = {64'd0, rad} * {64'd0, INV_PI_Q64};
        res  = (prod[127:64] + 64'd1) >> 1;
        if (i == 0) begin
            res = QUARTER_PI;
        end
        return signed'(res);
    endfunction

    // Reciprocal of the gain of a vectoring run of the given length, Q64.
    function automatic logic [63:0] f_inv_gain(input int stages);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        int i;
        x = 64'sd1 <<< 61;
        y = '0;
        for (i = 0; i < stages && i < TAB_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
            end else begin
                x = x - dx;
                y = y + dy;
            end
        end
        return f_div_wide(64'd1 << 61, 64'd0, unsigned'(x));
    endfunction

endpackage

// ===== design/ecefgeo_cordic.sv =====
module ecefgeo_cordic import ecefgeo_pkg::*; #(
    parameter int STAGES = DEF_CORDIC_STAGES,
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_y,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_angle,
    output logic [DATA_W-1:0]        o_len,
    output logic [SIDE_W-1:0]        o_side
);

    logic signed [DATA_W-1:0] r_x   [STAGES+1];
    logic signed [DATA_W-1:0] r_y   [STAGES+1];
    logic signed [DATA_W-1:0] r_ang [STAGES+1];
    logic                     r_zero[STAGES+1];
    logic                     r_vld [STAGES+1];
    logic [SIDE_W-1:0]        r_side[STAGES+1];

    logic signed [DATA_W-1:0] n_x;
    logic signed [DATA_W-1:0] n_y;
    logic signed [DATA_W-1:0] n_ang;

    // A vector in the left half-plane is turned by a quarter turn first.
    always_comb begin
        n_x   = i_x;
        n_y   = i_y;
        n_ang = '0;
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_x   = i_y;
                n_y   = -i_x;
                n_ang = signed'(HALF_PI);
            end else begin
                n_x   = -i_y;
                n_y   = i_x;
                n_ang = -signed'(HALF_PI);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0]  <= i_valid;
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_ang[0]  <= n_ang;
            r_zero[0] <= (i_x == 0) && (i_y == 0);
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam logic signed [DATA_W-1:0] STEP = f_step_angle(g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1]  <= r_vld[g];
                r_zero[g+1] <= r_zero[g];
                r_side[g+1] <= r_side[g];
                if (r_y[g] >= 0) begin
                    r_x[g+1]   <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1]   <= r_y[g] - (r_x[g] >>> g);
                    r_ang[g+1] <= r_ang[g] + STEP;
                end else begin
                    r_x[g+1]   <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1]   <= r_y[g] + (r_x[g] >>> g);
                    r_ang[g+1] <= r_ang[g] - STEP;
                end
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_angle = r_zero[STAGES] ? '0 : r_ang[STAGES];
    assign o_len   = unsigned'(r_x[STAGES]);
    assign o_side  = r_side[STAGES];

endmodule

// ===== design/ecefgeo_mul.sv =====
module ecefgeo_mul import ecefgeo_pkg::*; #(
    parameter int LANES  = 1,
    parameter int SHIFT  = 64,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_a [LANES],
    input  logic [DATA_W-1:0] i_b [LANES],
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_p [LANES],
    output logic [SIDE_W-1:0] o_side
);

    logic                  r_vld  [2];
    logic [SIDE_W-1:0]     r_side [2];
    logic [DATA_W-1:0]     r_p00  [LANES];
    logic [DATA_W-1:0]     r_p01  [LANES];
    logic [DATA_W-1:0]     r_p10  [LANES];
    logic [DATA_W-1:0]     r_p11  [LANES];
    logic [DATA_W-1:0]     r_p    [LANES];
    logic [2*DATA_W-1:0]   w_full [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            r_vld[1] <= 1'b0;
        end else if (i_en) begin
            r_vld[0]  <= i_valid;
            r_vld[1]  <= r_vld[0];
            r_side[0] <= i_side;
            r_side[1] <= r_side[0];
        end
    end

    // Four 32x32 partial products, then one 128-bit sum and the shift.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign w_full[l] = {r_p11[l], r_p00[l]}
                         + {32'd0, r_p01[l], 32'd0}
                         + {32'd0, r_p10[l], 32'd0};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p00[l] <= {32'd0, i_a[l][31:0]}  * {32'd0, i_b[l][31:0]};
                r_p01[l] <= {32'd0, i_a[l][31:0]}  * {32'd0, i_b[l][63:32]};
                r_p10[l] <= {32'd0, i_a[l][63:32]} * {32'd0, i_b[l][31:0]};
                r_p11[l] <= {32'd0, i_a[l][63:32]} * {32'd0, i_b[l][63:32]};
                r_p[l]   <= DATA_W'(w_full[l] >> SHIFT);
            end
        end

        assign o_p[l] = r_p[l];
    end

    assign o_valid = r_vld[1];
    assign o_side  = r_side[1];

endmodule

// ===== design/ecefgeo_div.sv =====
module ecefgeo_div import ecefgeo_pkg::*; #(
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_x [LANES],
    input  logic [DATA_W-1:0] i_d,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_q [LANES],
    output logic [SIDE_W-1:0] o_side
);

    logic [DATA_W-1:0] r_rem [QBITS+1][LANES];
    logic [QBITS-1:0]  r_q   [QBITS+1][LANES];
    logic              r_sat [QBITS+1][LANES];
    logic [DATA_W-1:0] r_d   [QBITS+1];
    logic              r_vld [QBITS+1];
    logic [SIDE_W-1:0] r_side[QBITS+1];

    // A ratio that would reach one is held at one; the quotient path then idles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0]  <= i_valid;
            r_side[0] <= i_side;
            r_d[0]    <= i_d;
            for (int l = 0; l < LANES; l++) begin
                r_sat[0][l] <= i_x[l] >= i_d;
                r_rem[0][l] <= (i_x[l] >= i_d) ? '0 : i_x[l];
                r_q[0][l]   <= '0;
            end
        end
    end

    for (genvar g = 0; g < QBITS; g++) begin : g_step
        logic [DATA_W:0] w_sh [LANES];
        logic            w_ge [LANES];

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                w_sh[l] = {r_rem[g][l], 1'b0};
                w_ge[l] = w_sh[l] >= {1'b0, r_d[g]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1]  <= r_vld[g];
                r_side[g+1] <= r_side[g];
                r_d[g+1]    <= r_d[g];
                for (int l = 0; l < LANES; l++) begin
                    r_sat[g+1][l] <= r_sat[g][l];
                    r_q[g+1][l]   <= {r_q[g][l][QBITS-2:0], w_ge[l]};
                    r_rem[g+1][l] <= w_ge[l] ? DATA_W'(w_sh[l] - {1'b0, r_d[g]})
                                             : w_sh[l][DATA_W-1:0];
                end
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_q[l] = r_sat[QBITS][l] ? (DATA_W'(1) << QBITS) : DATA_W'(r_q[QBITS][l]);
    end

    assign o_valid = r_vld[QBITS];
    assign o_side  = r_side[QBITS];

endmodule

// ===== design/ecefgeo_cfg.sv =====
module ecefgeo_cfg import ecefgeo_pkg::*; #(
    parameter int GUARD = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    localparam logic REG_A = 1'b0;
    localparam logic REG_B = 1'b1;

    typedef enum logic [2:0] {S_LOAD, S_DIV, S_UU, S_W, S_IDLE} t_state;

    t_state                 r_state;
    logic [5:0]             r_cnt;
    logic [RADIUS_BITS-1:0] r_a;
    logic [RADIUS_BITS-1:0] r_b;
    logic                   r_b_le_a;
    logic [DATA_W-1:0]      r_big;
    logic [DATA_W:0]        r_rem;
    logic [DATA_W-1:0]      r_lo;
    logic [2*DATA_W-1:0]    r_acc;
    logic [2*DATA_W-1:0]    r_mcand;
    logic [DATA_W-1:0]      r_mplier;
    logic [DATA_W-1:0]      r_u;
    logic [DATA_W-1:0]      r_w;

    logic                   w_write;
    logic [DATA_W-1:0]      w_ra;
    logic [DATA_W-1:0]      w_rb;
    logic                   w_ble;
    logic [DATA_W-1:0]      w_big;
    logic [DATA_W-1:0]      w_small;
    logic [DATA_W:0]        w_sh;
    logic                   w_ge;
    logic [DATA_W-1:0]      n_lo;
    logic [2*DATA_W-1:0]    n_acc;
    logic [DATA_W-1:0]      w_uu;

    assign w_write = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // A zero radius acts as one.
    assign w_ra    = (r_a == '0) ? DATA_W'(1) : DATA_W'(r_a);
    assign w_rb    = (r_b == '0) ? DATA_W'(1) : DATA_W'(r_b);
    assign w_ble   = w_rb <= w_ra;
    assign w_big   = w_ble ? w_ra : w_rb;
    assign w_small = w_ble ? w_rb : w_ra;

    assign w_sh  = {r_rem[DATA_W-1:0], r_lo[DATA_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_big};
    assign n_lo  = {r_lo[DATA_W-2:0], w_ge};
    assign n_acc = r_acc + (r_mplier[0] ? r_mcand : '0);
    assign w_uu  = DATA_W'(n_acc >> 62);

    always_comb begin
        unique case (paddr[3])
            REG_A:   prdata = DATA_W'(r_a);
            REG_B:   prdata = DATA_W'(r_b);
        endcase
    end

    // Ratio u = small/big by shift-subtract, then u^2 and W by shift-add.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a     <= RESET_A;
            r_b     <= RESET_B;
            r_state <= S_LOAD;
            r_cnt   <= '0;
        end else if (w_write) begin
            if (paddr[3] == REG_B) begin
                r_b <= pwdata[RADIUS_BITS-1:0];
            end else begin
                r_a <= pwdata[RADIUS_BITS-1:0];
            end
            r_state <= S_LOAD;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    r_b_le_a <= w_ble;
                    r_big    <= w_big;
                    r_rem    <= {3'd0, w_small[DATA_W-1:2]};
                    r_lo     <= {w_small[1:0], 62'd0};
                    r_cnt    <= '0;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= w_ge ? (w_sh - {1'b0, r_big}) : w_sh;
                    r_lo  <= n_lo;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_u      <= n_lo;
                        r_acc    <= '0;
                        r_mcand  <= {64'd0, n_lo};
                        r_mplier <= n_lo;
                        r_state  <= S_UU;
                    end
                end
                S_UU: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_acc    <= '0;
                        r_mcand  <= {64'd0, r_big};
                        r_mplier <= Q62_ONE - w_uu;
                        r_state  <= S_W;
                    end else begin
                        r_acc    <= n_acc;
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                S_W: begin
                    r_acc    <= n_acc;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_w     <= DATA_W'(n_acc >> (62 - GUARD));
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    assign o_cfg.busy   = r_state != S_IDLE;
    assign o_cfg.b_le_a = r_b_le_a;
    assign o_cfg.u      = r_u;
    assign o_cfg.w      = r_w;

    a_write_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_write |=> (r_state == S_LOAD))
        else $error("register write did not restart the ellipsoid setup");

    a_ratio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_u <= Q62_ONE))
        else $error("axis ratio exceeds one");

endmodule

// ===== design/ecef_to_geodetic_bowring_core.sv =====
// Throughput: one beat per cycle; three vectoring CORDICs, seven split multipliers and a
// 62-step divider pipeline are fully pipelined and stall together on the output side.
// Reset: synchronous, active low; the radius registers return to their defaults.
// After reset and after every register write, a serial setup of the axis ratio
// and ellipsoid term runs, and no input beat is taken until it ends.
module ecef_to_geodetic_bowring_core import ecefgeo_pkg::*; #(
    parameter int COORD_BITS    = DEF_COORD_BITS,
    parameter int ANGLE_BITS    = DEF_ANGLE_BITS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_x_mm,
    input  logic signed [COORD_BITS-1:0] i_y_mm,
    input  logic signed [COORD_BITS-1:0] i_z_mm,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [OUT_BITS-1:0]   o_latitude,
    output logic signed [OUT_BITS-1:0]   o_longitude,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready
);

    localparam int GUARD = (60 - COORD_BITS < 25) ? 60 - COORD_BITS : 25;
    localparam int RSH   = 62 - ANGLE_BITS;
    localparam logic signed [DATA_W-1:0] RND      = 64'sd1 <<< (RSH - 1);
    localparam logic [DATA_W-1:0]        INV_GAIN = f_inv_gain(CORDIC_STAGES);
    localparam logic signed [DATA_W-1:0] LAT_MAX  = signed'(HALF_PI);

    typedef struct packed {
        logic signed [DATA_W-1:0] lon;
        logic signed [DATA_W-1:0] zs;
        logic signed [DATA_W-1:0] ps;
        logic signed [DATA_W-1:0] psu;
        logic signed [DATA_W-1:0] zsu;
        logic signed [DATA_W-1:0] tx;
        logic signed [DATA_W-1:0] ty;
    } t_geo;

    typedef struct packed {
        t_geo g;
        logic rzero;
    } t_div_side;

    typedef struct packed {
        t_geo              g;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] c;
    } t_cube_side;

    typedef struct packed {
        logic signed [DATA_W-1:0] lon;
        logic signed [DATA_W-1:0] other;
        logic                     neg;
    } t_fin;

    function automatic logic [OUT_BITS-1:0] f_round(input logic signed [DATA_W-1:0] a);
        logic signed [DATA_W-1:0] r;
        logic [ANGLE_BITS-1:0]    aw;
        r  = (a + RND) >>> RSH;
        aw = r[ANGLE_BITS-1:0];
        return OUT_BITS'(signed'(aw));
    endfunction

    t_cfg w_cfg;
    logic w_en;
    logic r_out_valid;
    logic [OUT_BITS-1:0] r_lat;
    logic [OUT_BITS-1:0] r_lon;

    ecefgeo_cfg #(.GUARD(GUARD)) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The whole pipeline advances together whenever the output register can move.
    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en && !w_cfg.busy;

    // Longitude and horizontal distance.
    logic signed [DATA_W-1:0] w_xs, w_ys, w_zs;
    logic                     w_c1_vld;
    logic signed [DATA_W-1:0] w_lon;
    logic [DATA_W-1:0]        w_len1;
    logic [DATA_W-1:0]        w_c1_side;

    assign w_xs = DATA_W'(i_x_mm) <<< GUARD;
    assign w_ys = DATA_W'(i_y_mm) <<< GUARD;
    assign w_zs = DATA_W'(i_z_mm) <<< GUARD;

    ecefgeo_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(DATA_W)) u_cordic_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid && o_ready),
        .i_x     (w_xs),
        .i_y     (w_ys),
        .i_side  (w_zs),
        .o_valid (w_c1_vld),
        .o_angle (w_lon),
        .o_len   (w_len1),
        .o_side  (w_c1_side)
    );

    logic [DATA_W-1:0] w_ma_a [1];
    logic [DATA_W-1:0] w_ma_b [1];
    logic [DATA_W-1:0] w_ma_p [1];
    t_geo              w_ma_in, w_ma_out;
    logic              w_ma_vld;

    assign w_ma_a[0] = w_len1;
    assign w_ma_b[0] = INV_GAIN;
    always_comb begin
        w_ma_in     = '0;
        w_ma_in.lon = w_lon;
        w_ma_in.zs  = signed'(w_c1_side);
    end

    ecefgeo_mul #(.LANES(1), .SHIFT(64), .SIDE_W($bits(t_geo))) u_mul_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_c1_vld),
        .i_a     (w_ma_a),
        .i_b     (w_ma_b),
        .i_side  (w_ma_in),
        .o_valid (w_ma_vld),
        .o_p     (w_ma_p),
        .o_side  (w_ma_out)
    );

    // Scale p or Z by the axis ratio so that the parametric angle needs no division.
    logic [DATA_W-1:0] w_mb_a [2];
    logic [DATA_W-1:0] w_mb_b [2];
    logic [DATA_W-1:0] w_mb_p [2];
    t_geo              w_mb_in, w_mb_out, w_th;
    logic              w_mb_vld;

    always_comb begin
        w_mb_in    = w_ma_out;
        w_mb_in.ps = signed'(w_ma_p[0]);
    end
    assign w_mb_a[0] = w_ma_p[0];
    assign w_mb_b[0] = w_cfg.u;
    assign w_mb_a[1] = unsigned'((w_ma_out.zs < 0) ? -w_ma_out.zs : w_ma_out.zs);
    assign w_mb_b[1] = w_cfg.u;

    ecefgeo_mul #(.LANES(2), .SHIFT(62), .SIDE_W($bits(t_geo))) u_mul_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ma_vld),
        .i_a     (w_mb_a),
        .i_b     (w_mb_b),
        .i_side  (w_mb_in),
        .o_valid (w_mb_vld),
        .o_p     (w_mb_p),
        .o_side  (w_mb_out)
    );

    always_comb begin
        w_th     = w_mb_out;
        w_th.psu = signed'(w_mb_p[0]);
        w_th.zsu = (w_mb_out.zs < 0) ? -signed'(w_mb_p[1]) : signed'(w_mb_p[1]);
        w_th.tx  = w_cfg.b_le_a ? w_th.psu : w_mb_out.ps;
        w_th.ty  = w_cfg.b_le_a ? w_mb_out.zs : w_th.zsu;
    end

    // Parametric angle vector length.
    logic              w_c2_vld;
    logic signed [DATA_W-1:0] w_c2_ang;
    logic [DATA_W-1:0] w_len2;
    t_geo              w_c2_side;

    ecefgeo_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W($bits(t_geo))) u_cordic_theta (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mb_vld),
        .i_x     (w_th.tx),
        .i_y     (w_th.ty),
        .i_side  (w_th),
        .o_valid (w_c2_vld),
        .o_angle (w_c2_ang),
        .o_len   (w_len2),
        .o_side  (w_c2_side)
    );

    logic [DATA_W-1:0] w_mc_a [1];
    logic [DATA_W-1:0] w_mc_b [1];
    logic [DATA_W-1:0] w_mc_p [1];
    t_geo              w_mc_out;
    logic              w_mc_vld;

    assign w_mc_a[0] = w_len2;
    assign w_mc_b[0] = INV_GAIN;

    ecefgeo_mul #(.LANES(1), .SHIFT(64), .SIDE_W($bits(t_geo))) u_mul_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_c2_vld),
        .i_a     (w_mc_a),
        .i_b     (w_mc_b),
        .i_side  (w_c2_side),
        .o_valid (w_mc_vld),
        .o_p     (w_mc_p),
        .o_side  (w_mc_out)
    );

    // sin and cos of the parametric angle as Q62 ratios.
    logic [DATA_W-1:0] w_dv_x [2];
    logic [DATA_W-1:0] w_dv_q [2];
    t_div_side         w_dv_in, w_dv_out;
    logic              w_dv_vld;
    logic [DATA_W-1:0] w_sin, w_cos;

    assign w_dv_x[0] = unsigned'((w_mc_out.ty < 0) ? -w_mc_out.ty : w_mc_out.ty);
    assign w_dv_x[1] = unsigned'(w_mc_out.tx);
    assign w_dv_in.g     = w_mc_out;
    assign w_dv_in.rzero = w_mc_p[0] == '0;

    ecefgeo_div #(.LANES(2), .SIDE_W($bits(t_div_side))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mc_vld),
        .i_x     (w_dv_x),
        .i_d     (w_mc_p[0]),
        .i_side  (w_dv_in),
        .o_valid (w_dv_vld),
        .o_q     (w_dv_q),
        .o_side  (w_dv_out)
    );

    // A zero vector has sin 0 and cos 1.
    assign w_sin = w_dv_out.rzero ? '0 : w_dv_q[0];
    assign w_cos = w_dv_out.rzero ? Q62_ONE : w_dv_q[1];

    logic [DATA_W-1:0] w_md_a [2];
    logic [DATA_W-1:0] w_md_b [2];
    logic [DATA_W-1:0] w_md_p [2];
    t_cube_side        w_md_in, w_md_out;
    logic              w_md_vld;

    assign w_md_a[0] = w_sin;
    assign w_md_b[0] = w_sin;
    assign w_md_a[1] = w_cos;
    assign w_md_b[1] = w_cos;
    assign w_md_in.g = w_dv_out.g;
    assign w_md_in.s = w_sin;
    assign w_md_in.c = w_cos;

    ecefgeo_mul #(.LANES(2), .SHIFT(62), .SIDE_W($bits(t_cube_side))) u_mul_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv_vld),
        .i_a     (w_md_a),
        .i_b     (w_md_b),
        .i_side  (w_md_in),
        .o_valid (w_md_vld),
        .o_p     (w_md_p),
        .o_side  (w_md_out)
    );

    logic [DATA_W-1:0] w_me_a [2];
    logic [DATA_W-1:0] w_me_b [2];
    logic [DATA_W-1:0] w_me_p [2];
    t_geo              w_me_out;
    logic              w_me_vld;

    assign w_me_a[0] = w_md_p[0];
    assign w_me_b[0] = w_md_out.s;
    assign w_me_a[1] = w_md_p[1];
    assign w_me_b[1] = w_md_out.c;

    ecefgeo_mul #(.LANES(2), .SHIFT(62), .SIDE_W($bits(t_geo))) u_mul_cube (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_md_vld),
        .i_a     (w_me_a),
        .i_b     (w_me_b),
        .i_side  (w_md_out.g),
        .o_valid (w_me_vld),
        .o_p     (w_me_p),
        .o_side  (w_me_out)
    );

    logic [DATA_W-1:0] w_mf_a [2];
    logic [DATA_W-1:0] w_mf_b [2];
    logic [DATA_W-1:0] w_mf_p [2];
    t_geo              w_mf_out;
    logic              w_mf_vld;

    assign w_mf_a[0] = w_cfg.w;
    assign w_mf_b[0] = w_me_p[0];
    assign w_mf_a[1] = w_cfg.w;
    assign w_mf_b[1] = w_me_p[1];

    ecefgeo_mul #(.LANES(2), .SHIFT(62), .SIDE_W($bits(t_geo))) u_mul_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_me_vld),
        .i_a     (w_mf_a),
        .i_b     (w_mf_b),
        .i_side  (w_me_out),
        .o_valid (w_mf_vld),
        .o_p     (w_mf_p),
        .o_side  (w_mf_out)
    );

    // One of numerator and denominator still carries the ratio scale.
    logic signed [DATA_W-1:0] w_sws3, w_pre, w_other;
    logic [DATA_W-1:0] w_mg_a [1];
    logic [DATA_W-1:0] w_mg_b [1];
    logic [DATA_W-1:0] w_mg_p [1];
    t_fin              w_mg_in, w_mg_out;
    logic              w_mg_vld;

    assign w_sws3  = (w_mf_out.ty < 0) ? -signed'(w_mf_p[0]) : signed'(w_mf_p[0]);
    assign w_pre   = w_cfg.b_le_a ? w_mf_out.ps - signed'(w_mf_p[1]) : w_mf_out.zs - w_sws3;
    assign w_other = w_cfg.b_le_a ? w_mf_out.zsu + w_sws3 : w_mf_out.psu + signed'(w_mf_p[1]);
    assign w_mg_a[0]     = unsigned'((w_pre < 0) ? -w_pre : w_pre);
    assign w_mg_b[0]     = w_cfg.u;
    assign w_mg_in.lon   = w_mf_out.lon;
    assign w_mg_in.other = w_other;
    assign w_mg_in.neg   = w_pre < 0;

    ecefgeo_mul #(.LANES(1), .SHIFT(62), .SIDE_W($bits(t_fin))) u_mul_fin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mf_vld),
        .i_a     (w_mg_a),
        .i_b     (w_mg_b),
        .i_side  (w_mg_in),
        .o_valid (w_mg_vld),
        .o_p     (w_mg_p),
        .o_side  (w_mg_out)
    );

    logic signed [DATA_W-1:0] w_scaled, w_num, w_den;

    assign w_scaled = w_mg_out.neg ? -signed'(w_mg_p[0]) : signed'(w_mg_p[0]);
    assign w_den    = w_cfg.b_le_a ? w_scaled : w_mg_out.other;
    assign w_num    = w_cfg.b_le_a ? w_mg_out.other : w_scaled;

    logic                     w_c3_vld;
    logic signed [DATA_W-1:0] w_lat;
    logic [DATA_W-1:0]        w_len3;
    logic [DATA_W-1:0]        w_c3_side;
    logic signed [DATA_W-1:0] w_lat_sat;

    ecefgeo_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(DATA_W)) u_cordic_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mg_vld),
        .i_x     (w_den),
        .i_y     (w_num),
        .i_side  (unsigned'(w_mg_out.lon)),
        .o_valid (w_c3_vld),
        .o_angle (w_lat),
        .o_len   (w_len3),
        .o_side  (w_c3_side)
    );

    // Points near the centre can give a latitude past a quarter turn; it is clipped.
    always_comb begin
        w_lat_sat = w_lat;
        if (w_lat > LAT_MAX) begin
            w_lat_sat = LAT_MAX;
        end
        if (w_lat < -LAT_MAX) begin
            w_lat_sat = -LAT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_c3_vld;
            r_lat       <= f_round(w_lat_sat);
            r_lon       <= f_round(signed'(w_c3_side));
        end
    end

    assign o_valid     = r_out_valid;
    assign o_latitude  = signed'(r_lat);
    assign o_longitude = signed'(r_lon);

    a_setup_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg.busy |-> !o_ready)
        else $error("input beat accepted during ellipsoid setup");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_ready)
        else $error("input beat accepted while the pipeline is stalled");

    a_len_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_c3_vld && (w_den == w_num) && (w_len3 == '0)) |-> (w_lat == '0) || (w_den != '0))
        else $error("zero latitude vector gave a nonzero angle");

endmodule
